[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bracket balance checker: byte codes of
// the six brackets, bracket kinds, stack operations and verdict codes.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // bytes that take part in the check
    localparam logic [7:0] CHR_OPEN_ROUND   = 8'h28;  // (
    localparam logic [7:0] CHR_CLOSE_ROUND  = 8'h29;  // )
    localparam logic [7:0] CHR_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [7:0] CHR_CLOSE_CURLY  = 8'h7D;  // }
    localparam logic [7:0] CHR_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [7:0] CHR_CLOSE_SQUARE = 8'h5D;  // ]

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // bracket kind as kept on the stack
    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // stack operation decoded from one byte
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_code_t;

    // verdict codes
    typedef enum logic [2:0] {
        ERR_NONE            = 3'd0,
        ERR_MISMATCH        = 3'd1,
        ERR_UNMATCHED_CLOSE = 3'd2,
        ERR_UNCLOSED_OPEN   = 3'd3,
        ERR_OVERFLOW        = 3'd4
    } err_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        op_code_t op;
        kind_t    kind;
        logic     last;
    } op_item_t;

endpackage

[rtl/bbc_front.sv]
// ----------------------------------------------------------------------------
// bbc_front
// Classifies one input byte into a stack operation and a bracket kind.
// ----------------------------------------------------------------------------
module bbc_front
    import bbc_pkg::*;
(
    input  logic [7:0] char_in,
    input  logic       last,
    output op_item_t   item
);

    // byte decode
    always_comb
    begin
        item.last = last;
        case (char_in)
            CHR_OPEN_ROUND:
            begin
                item.op   = OP_PUSH;
                item.kind = KIND_ROUND;
            end
            CHR_OPEN_CURLY:
            begin
                item.op   = OP_PUSH;
                item.kind = KIND_CURLY;
            end
            CHR_OPEN_SQUARE:
            begin
                item.op   = OP_PUSH;
                item.kind = KIND_SQUARE;
            end
            CHR_CLOSE_ROUND:
            begin
                item.op   = OP_POP;
                item.kind = KIND_ROUND;
            end
            CHR_CLOSE_CURLY:
            begin
                item.op   = OP_POP;
                item.kind = KIND_CURLY;
            end
            CHR_CLOSE_SQUARE:
            begin
                item.op   = OP_POP;
                item.kind = KIND_SQUARE;
            end
            default:
            begin
                item.op   = OP_NONE;
                item.kind = KIND_NONE;
            end
        endcase
    end

endmodule

[rtl/bbc_queue.sv]
// ----------------------------------------------------------------------------
// bbc_queue
// Short queue of classified items between front and back, so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module bbc_queue
    import bbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_stall,
    input  op_item_t wr_data,
    output logic     rd_valid,
    input  logic     rd_take,
    output op_item_t rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_item_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               wr_en;
    logic               rd_en;

    // handshake
    assign wr_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_take && rd_valid;
    assign rd_data  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    // fill level never runs past the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("bbc_queue: count above depth");

    // back side only takes an item that is there
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_take |-> count_reg != '0)
        else $error("bbc_queue: take from empty queue");

    // a lone write grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("bbc_queue: count lost a write");

    // a lone read shrinks the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && !wr_en |=> count_reg == $past(count_reg) - 1'b1)
        else $error("bbc_queue: count lost a read");
`endif

endmodule

[rtl/bbc_back.sv]
// ----------------------------------------------------------------------------
// bbc_back
// Bracket stack engine: one classified item per cycle (a final one waits on a
// stalled verdict), keeps the string's first error and registers its verdict.
// ----------------------------------------------------------------------------
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_take,
    input  op_item_t item,
    output logic     out_valid,
    input  logic     out_stall,
    output logic     is_balanced,
    output logic [2:0] error_code
);

    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    // stack memory, one write port and one registered read port
    kind_t              stack_mem [STACK_DEPTH];
    kind_t              top_reg;

    logic [LVL_W-1:0]   lvl_reg;
    logic [LVL_W-1:0]   lvl_next;
    logic [LVL_W-1:0]   lvl_below;
    err_t               err_reg;
    err_t               err_next;
    err_t               verdict;
    logic               out_valid_reg;
    logic               is_balanced_reg;
    err_t               error_code_reg;
    logic               out_free;
    logic               fire;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    // take an item when the result register can hold a verdict
    assign out_free  = !out_valid_reg || !out_stall;
    assign item_take = item_valid && (!item.last || out_free);
    assign fire      = item_take;

    // stack step and error tracking
    always_comb
    begin
        lvl_next = lvl_reg;
        err_next = err_reg;
        wr_en    = 1'b0;
        wr_addr  = lvl_reg[AW-1:0];
        verdict  = err_reg;
        if (fire && (err_reg == ERR_NONE))
        begin
            case (item.op)
                OP_PUSH:
                begin
                    if (lvl_reg == LVL_W'(STACK_DEPTH))
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        lvl_next = lvl_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (lvl_reg == '0)
                    begin
                        err_next = ERR_UNMATCHED_CLOSE;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1;
                        if (top_reg != item.kind)
                        begin
                            err_next = ERR_MISMATCH;
                        end
                    end
                end
                default:
                begin
                    lvl_next = lvl_reg;
                end
            endcase
        end
        // verdict, computed before the string clears
        verdict = err_next;
        if ((err_next == ERR_NONE) && (lvl_next != '0))
        begin
            verdict = ERR_UNCLOSED_OPEN;
        end
        if (fire && item.last)
        begin
            lvl_next = '0;
            err_next = ERR_NONE;
        end
    end

    // prefetch the entry just below the new level as the next top
    assign lvl_below = lvl_next - 1'b1;
    assign rd_addr   = lvl_below[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= item.kind;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            top_reg <= item.kind;
        end
        else
        begin
            top_reg <= stack_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg       <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lvl_reg <= lvl_next;
            err_reg <= err_next;
            if (fire && item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire && item.last)
        begin
            is_balanced_reg <= (verdict == ERR_NONE);
            error_code_reg  <= verdict;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_balanced = is_balanced_reg;
    assign error_code  = error_code_reg;

`ifndef SYNTHESIS
    // the level never passes the stack depth
    assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_W'(STACK_DEPTH))
        else $error("bbc_back: stack level above depth");

    // the final item clears the string state
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last |=> (lvl_reg == '0) && (err_reg == ERR_NONE))
        else $error("bbc_back: string state not cleared");

    // once an error is held the stack does not move
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.last && (err_reg != ERR_NONE) |=> lvl_reg == $past(lvl_reg))
        else $error("bbc_back: stack moved after error");

    // verdict flag agrees with the code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (is_balanced_reg == (error_code_reg == ERR_NONE)))
        else $error("bbc_back: flag and code disagree");
`endif

endmodule

[rtl/bracket_balance_checker.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Balanced-bracket check over a byte stream with a bounded kind stack.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid/in_stall    char_in[7:0], last
//   out      from block out_valid/out_stall  is_balanced, error_code[2:0]
//
// One byte per cycle while in_stall is low; the stack memory has one write
// port and one registered read port, with the top entry prefetched every cycle.
// The verdict is registered as the back end takes the final byte off the queue.
// Reset clears level, error, out_valid and queue state only, not the stack entries.
// A stalled verdict holds the back end only when the next final byte arrives.
// ----------------------------------------------------------------------------
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_balanced,
    output logic [2:0] error_code
);

    op_item_t front_item;
    op_item_t back_item;
    logic     back_valid;
    logic     back_take;

    // classify bytes
    bbc_front u_front
    (
        .char_in (char_in),
        .last    (last),
        .item    (front_item)
    );

    // decoupling queue
    bbc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_stall (in_stall),
        .wr_data  (front_item),
        .rd_valid (back_valid),
        .rd_take  (back_take),
        .rd_data  (back_item)
    );

    // stack engine and verdict register
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (back_valid),
        .item_take   (back_take),
        .item        (back_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_balanced (is_balanced),
        .error_code  (error_code)
    );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for bracket_balance_checker
// Sends byte strings through the valid/stall input channel and checks every
// verdict against a bracket-stack predictor or a hand-typed one. A short table of
// hand-picked strings runs first. Random strings follow: nested, mismatched,
// unclosed, over-closed, overflowing and pure noise. Both channels idle at random,
// and the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bbc_pkg::*;

    localparam int STACK_DEPTH    = 64;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int DIRECTED_ROWS  = 23;

    // one input item, with an optional hand-typed verdict
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         chk;
        logic       bal;
        err_t       err;
    } stim_t;

    typedef struct packed {
        logic bal;
        err_t err;
    } verdict_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic       is_balanced;
    logic [2:0] error_code;

    stim_t    stim_q[$];
    verdict_t verdict_q[$];

    // predictor state
    kind_t open_stack[STACK_DEPTH];
    int    open_level;
    err_t  pending_err;

    int  errors;
    int  counted_items;
    int  bytes_sent;
    int  strings_sent;
    int  results_seen;
    int  deepest;
    int  code_hits[5];
    bit  sending_done;

    // directed strings: simple cases carry their verdict, the rest use the predictor
    stim_t directed_tbl [DIRECTED_ROWS] = '{
        '{CHR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_ROUND,  1'b1, 1'b1, 1'b1, ERR_NONE},
        '{CHR_OPEN_SQUARE,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_CURLY,  1'b1, 1'b1, 1'b0, ERR_MISMATCH},
        '{CHR_CLOSE_ROUND,  1'b1, 1'b1, 1'b0, ERR_UNMATCHED_CLOSE},
        '{CHR_OPEN_CURLY,   1'b1, 1'b1, 1'b0, ERR_UNCLOSED_OPEN},
        '{8'h00,            1'b1, 1'b1, 1'b1, ERR_NONE},
        '{8'hFF,            1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_OPEN_SQUARE,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{8'h00,            1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_SQUARE, 1'b1, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_SQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_ROUND,  1'b1, 1'b1, 1'b0, ERR_UNMATCHED_CLOSE},
        '{CHR_OPEN_CURLY,   1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_OPEN_SQUARE,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_ROUND,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_SQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_CURLY,  1'b1, 1'b0, 1'b0, ERR_NONE},
        '{CHR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_SQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CHR_CLOSE_ROUND,  1'b1, 1'b1, 1'b0, ERR_MISMATCH}
    };

    bracket_balance_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_balanced (is_balanced),
        .error_code  (error_code)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // byte classification
    function automatic kind_t open_kind(logic [7:0] b);
        case (b)
            CHR_OPEN_ROUND:  return KIND_ROUND;
            CHR_OPEN_CURLY:  return KIND_CURLY;
            CHR_OPEN_SQUARE: return KIND_SQUARE;
            default:         return KIND_NONE;
        endcase
    endfunction

    function automatic kind_t close_kind(logic [7:0] b);
        case (b)
            CHR_CLOSE_ROUND:  return KIND_ROUND;
            CHR_CLOSE_CURLY:  return KIND_CURLY;
            CHR_CLOSE_SQUARE: return KIND_SQUARE;
            default:          return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] open_chr(kind_t k);
        case (k)
            KIND_ROUND: return CHR_OPEN_ROUND;
            KIND_CURLY: return CHR_OPEN_CURLY;
            default:    return CHR_OPEN_SQUARE;
        endcase
    endfunction

    function automatic logic [7:0] close_chr(kind_t k);
        case (k)
            KIND_ROUND: return CHR_CLOSE_ROUND;
            KIND_CURLY: return CHR_CLOSE_CURLY;
            default:    return CHR_CLOSE_SQUARE;
        endcase
    endfunction

    function automatic bit is_bracket(logic [7:0] b);
        return open_kind(b) != KIND_NONE || close_kind(b) != KIND_NONE;
    endfunction

    // any byte that is not a bracket, terminator included
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_bracket(b));
        return b;
    endfunction

    // half brackets, half arbitrary bytes
    function automatic logic [7:0] any_byte();
        kind_t k;
        k = kind_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 1) == 0)
            return open_chr(k);
        else
            return close_chr(k);
    endfunction

    // bracket-stack predictor: one byte in, a verdict on the final byte
    task automatic scan_byte(input logic [7:0] ch, input logic fin,
                             output bit has_verdict, output verdict_t v);
        kind_t ko;
        kind_t kc;
        ko = open_kind(ch);
        kc = close_kind(ch);
        v = '{1'b0, ERR_NONE};
        if (pending_err == ERR_NONE)
        begin
            if (ko != KIND_NONE)
            begin
                if (open_level >= STACK_DEPTH)
                    pending_err = ERR_OVERFLOW;
                else
                begin
                    open_stack[open_level] = ko;
                    open_level++;
                    if (open_level > deepest)
                        deepest = open_level;
                end
            end
            else if (kc != KIND_NONE)
            begin
                if (open_level == 0)
                    pending_err = ERR_UNMATCHED_CLOSE;
                else
                begin
                    open_level--;
                    if (open_stack[open_level] != kc)
                        pending_err = ERR_MISMATCH;
                end
            end
        end
        has_verdict = fin;
        if (fin)
        begin
            v.err = pending_err;
            if (v.err == ERR_NONE && open_level != 0)
                v.err = ERR_UNCLOSED_OPEN;
            v.bal = (v.err == ERR_NONE);
            open_level  = 0;
            pending_err = ERR_NONE;
        end
    endtask

    // queue one byte for the sender
    task automatic queue_byte(logic [7:0] ch, logic fin);
        stim_t s;
        s = '{ch, fin, 1'b0, 1'b0, ERR_NONE};
        stim_q.push_back(s);
        counted_items++;
    endtask

    // build one random string; mode picks its shape
    task automatic queue_string();
        logic [7:0] s[$];
        kind_t      ks[$];
        kind_t      k;
        int         mode;
        int         n;
        int         lvl_max;
        int         i;
        int         j;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            mode = 0;          // balanced
        else if (pick < 60)
            mode = 1;          // mismatch
        else if (pick < 68)
            mode = 2;          // extra close
        else if (pick < 76)
            mode = 3;          // left open
        else if (pick < 78)
            mode = 4;          // overflow
        else if (pick < 80)
            mode = 5;          // full depth, balanced
        else
            mode = 6;          // pure noise
        n = $urandom_range(1, 16);
        lvl_max = $urandom_range(1, 6);

        if (mode == 6)
        begin
            for (i = 0; i < n; i++)
                s.push_back(any_byte());
        end
        else
        begin
            // well-formed body with noise sprinkled in
            for (i = 0; i < n; i++)
            begin
                if (ks.size() < lvl_max && (ks.size() == 0 || $urandom_range(0, 1) == 1))
                begin
                    k = kind_t'($urandom_range(0, 2));
                    ks.push_back(k);
                    s.push_back(open_chr(k));
                end
                else
                begin
                    k = ks.pop_back();
                    s.push_back(close_chr(k));
                end
                if ($urandom_range(0, 3) == 0)
                    s.push_back(noise_byte());
            end
            case (mode)
                1:
                begin
                    if (ks.size() == 0)
                    begin
                        k = kind_t'($urandom_range(0, 2));
                        ks.push_back(k);
                        s.push_back(open_chr(k));
                    end
                    k = ks.pop_back();
                    s.push_back(close_chr(kind_t'((int'(k) + $urandom_range(1, 2)) % 3)));
                    while (ks.size() > 0)
                        s.push_back(close_chr(ks.pop_back()));
                end
                2:
                begin
                    while (ks.size() > 0)
                        s.push_back(close_chr(ks.pop_back()));
                    s.push_back(close_chr(kind_t'($urandom_range(0, 2))));
                end
                3:
                begin
                    k = kind_t'($urandom_range(0, 2));
                    ks.push_back(k);
                    s.push_back(open_chr(k));
                    j = $urandom_range(0, ks.size() - 1);
                    repeat (j)
                        s.push_back(close_chr(ks.pop_back()));
                end
                4, 5:
                begin
                    while (ks.size() < STACK_DEPTH)
                    begin
                        k = kind_t'($urandom_range(0, 2));
                        ks.push_back(k);
                        s.push_back(open_chr(k));
                    end
                    if (mode == 4)
                        s.push_back(open_chr(kind_t'($urandom_range(0, 2))));
                    else
                    begin
                        while (ks.size() > 0)
                            s.push_back(close_chr(ks.pop_back()));
                    end
                end
                default:
                begin
                    while (ks.size() > 0)
                        s.push_back(close_chr(ks.pop_back()));
                end
            endcase
            // brackets after an error must be ignored
            if (mode >= 1 && mode <= 4 && $urandom_range(0, 1) == 1)
            begin
                j = $urandom_range(1, 4);
                repeat (j)
                    s.push_back(any_byte());
            end
        end
        // sometimes end on a terminator or a noise byte
        if ($urandom_range(0, 2) == 0)
            s.push_back($urandom_range(0, 1) ? 8'h00 : noise_byte());
        for (i = 0; i < s.size(); i++)
            queue_byte(s[i], i == s.size() - 1);
    endtask

    // reset and end of run
    initial
    begin : main
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (sending_done);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d bytes in %0d strings, nesting up to %0d", bytes_sent,
                 strings_sent, deepest);
        $display("verdicts: balanced %0d, mismatch %0d, unmatched close %0d, %s",
                 code_hits[0], code_hits[1], code_hits[2],
                 $sformatf("open %0d, overflow %0d", code_hits[3], code_hits[4]));
        if (errors == 0)
            $display("bracket_balance_checker test passed");
        else
            $display("bracket_balance_checker test failed");
        $finish;
    end

    // sender: directed table then random strings, in bursts with gaps
    initial
    begin : sender
        stim_t    cur;
        verdict_t v;
        verdict_t tv;
        bit       has_v;
        int       gap_left;
        int       burst_left;
        int       i;
        in_valid <= 1'b0;
        char_in  <= 8'h00;
        last     <= 1'b0;
        open_level    = 0;
        pending_err   = ERR_NONE;
        errors        = 0;
        counted_items = 0;
        bytes_sent    = 0;
        strings_sent  = 0;
        results_seen  = 0;
        deepest       = 0;
        sending_done  = 1'b0;
        for (i = 0; i < 5; i++)
            code_hits[i] = 0;
        for (i = 0; i < DIRECTED_ROWS; i++)
            stim_q.push_back(directed_tbl[i]);
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
            queue_string();
        gap_left   = 0;
        burst_left = $urandom_range(1, 30);
        wait (rst_n);
        while (!sending_done)
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                scan_byte(cur.ch, cur.fin, has_v, v);
                bytes_sent++;
                if (has_v)
                begin
                    tv = '{cur.bal, cur.err};
                    verdict_q.push_back(cur.chk ? tv : v);
                    strings_sent++;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || stim_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                    else
                        sending_done = 1'b1;
                end
                else
                begin
                    cur = stim_q.pop_front();
                    in_valid <= 1'b1;
                    char_in  <= cur.ch;
                    last     <= cur.fin;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int mode_left;
        bit held_off;
        out_stall <= 1'b0;
        mode      = 0;
        mode_left = 50;
        held_off  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= 40)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
                mode_left--;
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 150);
                end
            end
        end
    end

    // verdict checker
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected verdict is_balanced=%0b error_code=%0d", $time,
                         is_balanced, error_code);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (int'(want.err) < 5)
                    code_hits[int'(want.err)]++;
                if (is_balanced !== want.bal)
                begin
                    $display("%0t: is_balanced expected %0b actual %0b", $time, want.bal,
                             is_balanced);
                    errors++;
                end
                if (error_code !== want.err)
                begin
                    $display("%0t: error_code expected %0d actual %0d", $time, want.err,
                             error_code);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item accepted on either side
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
            $display("bracket_balance_checker test failed");
            $finish;
        end
    end

endmodule
